FILE: sv/bmf_pkg.sv
// Shared constants and types for the 5x5 box mean filter.
package bmf_pkg;

    // Pixel and window geometry
    localparam int PIX_W    = 8;
    localparam int WIN      = 5;
    localparam int WIN_HALF = WIN / 2;
    localparam int LINES    = WIN - 1;
    localparam int SLOT_W   = $clog2(LINES);

    // Configuration registers
    localparam int WIDTH_CFG_W = 11;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam logic [WIDTH_CFG_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [HEIGHT_W-1:0]    RESET_HEIGHT = 16'd480;
    localparam int MIN_DIM = 5;

    // Row counter runs two rows past the image while flushing
    localparam int ROW_W = HEIGHT_W + 1;

    // Sum widths: one column of five pixels, then the whole window
    localparam int COLSUM_W = $clog2(WIN * 255 + 1);
    localparam int SUM_W    = $clog2(WIN * WIN * 255 + 1);

    // Divide by 25 as multiply by ceil(2^17 / 25), exact for sums below 43690
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 17;
    localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // One window column as held by a cell
    typedef struct packed {
        logic [WIN-1:0][PIX_W-1:0] pix;
        logic [COLSUM_W-1:0]       sum;
    } col_t;

endpackage

FILE: sv/bmf_if.sv
// Stream interfaces for pixel items and result items.
interface bmf_in_if;
    import bmf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             flush;

    modport source (output valid, pixel_in, flush, input ready);
    modport sink   (input valid, pixel_in, flush, output ready);
endinterface

interface bmf_out_if;
    import bmf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             last_pixel;

    modport source (output valid, pixel_out, last_pixel, input ready);
    modport sink   (input valid, pixel_out, last_pixel, output ready);
endinterface

FILE: sv/bmf_win_cell.sv
// One window column cell: holds five pixels and their sum, adds into the window total.
module bmf_win_cell (
    input  logic                       clk,
    input  logic                       shift_en,
    input  bmf_pkg::col_t              col_in,
    output bmf_pkg::col_t              col_out,
    input  logic [bmf_pkg::SUM_W-1:0]  acc_in,
    output logic [bmf_pkg::SUM_W-1:0]  acc_out
);
    import bmf_pkg::*;

    col_t col_reg;

    // Column moves one cell left per accepted pixel
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    // Running window sum passes along the chain
    assign acc_out = acc_in + SUM_W'(col_reg.sum);

endmodule

FILE: sv/box_mean_filter_5x5_core.sv
// Top level: line buffers, 5x5 window cell chain and divide-by-25 output pipe.
// Throughput: one item per clock, no gaps, limited only by the output handshake.
// Pipeline: the item that causes a result passes the s1, s2 (window cell), s3, s4 and output registers;
//   the result for a pixel is caused 2*image_width+2 items after that pixel.
// Reset: counters and pipeline valids clear, width/height go to 640/480;
//   line buffers and window are not cleared and need no clearing pass.
module box_mean_filter_5x5_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]   cfg_data,
    bmf_in_if.sink                           pixels,
    bmf_out_if.source                        results
);
    import bmf_pkg::*;

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (CW > WIDTH_CFG_W) ? CW : WIDTH_CFG_W;
    localparam int CW1 = CW + 1;
    localparam int RW1 = ROW_W + 1;

    // Configuration and position state
    logic [WIDTH_CFG_W-1:0] width_cfg_reg;
    logic [HEIGHT_W-1:0]    height_cfg_reg;
    logic [ROW_W-1:0]       in_row_reg, in_row_next;
    logic [AW-1:0]          in_col_reg, in_col_next;

    // Effective (saturated) image size
    logic [EW-1:0]       w_ext;
    logic [CW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    // Accept-stage decode
    logic             en, take, act, flushing, ignore_item, col_ge2, has_res;
    logic             res_filt, res_last, wrap, mem_wr;
    logic [CW-1:0]    col_ext, out_col;
    logic [ROW_W-1:0] out_row, h_ext;
    logic [PIX_W-1:0] pix_new;

    // Line buffers: one word per column, one byte per buffered row
    logic [LINES-1:0][PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [LINES-1:0][PIX_W-1:0] line_rd_reg;

    // Pipeline registers
    logic              s1_valid_reg, s1_res_reg, s1_filt_reg, s1_last_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s2_res_reg, s2_filt_reg, s2_last_reg;
    logic              s3_valid_reg, s3_filt_reg, s3_last_reg;
    logic [SUM_W-1:0]  s3_sum_reg;
    logic [PIX_W-1:0]  s3_center_reg;
    logic              s4_valid_reg, s4_filt_reg, s4_last_reg;
    logic [PROD_W-1:0] s4_prod_reg;
    logic [PIX_W-1:0]  s4_center_reg;
    logic              out_valid_reg, out_last_reg;
    logic [PIX_W-1:0]  out_pix_reg;

    // Window chain
    col_t             new_col;
    logic             win_shift;
    col_t             cell_col [WIN];
    logic [SUM_W-1:0] cell_acc [WIN+1];

    // Saturate width to MIN_DIM..MAX_WIDTH, height to at least MIN_DIM
    always_comb
    begin
        w_ext = EW'(width_cfg_reg);
        if (w_ext < EW'(MIN_DIM))
            w_eff = CW'(MIN_DIM);
        else if (w_ext > EW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(w_ext);
        h_eff = (height_cfg_reg < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : height_cfg_reg;
    end

    // Whole pipe advances when the output register is free or being drained
    assign en           = !out_valid_reg || results.ready;
    assign pixels.ready = en;
    assign take         = pixels.valid && en;

    // Decode the output position and border/last flags for this item
    always_comb
    begin
        col_ext     = CW'(in_col_reg);
        h_ext       = ROW_W'(h_eff);
        flushing    = in_row_reg >= h_ext;
        ignore_item = !flushing && pixels.flush;
        act         = take && !ignore_item;
        pix_new     = flushing ? '0 : pixels.pixel_in;
        col_ge2     = col_ext >= CW'(WIN_HALF);
        has_res     = (in_row_reg > ROW_W'(WIN_HALF))
                      || ((in_row_reg == ROW_W'(WIN_HALF)) && col_ge2);
        out_row     = col_ge2 ? in_row_reg - ROW_W'(WIN_HALF)
                              : in_row_reg - ROW_W'(WIN_HALF + 1);
        out_col     = col_ge2 ? col_ext - CW'(WIN_HALF)
                              : w_eff - CW'(WIN_HALF) + col_ext;
        res_filt    = (out_row >= ROW_W'(WIN_HALF))
                      && ((RW1'(out_row) + RW1'(WIN_HALF)) < RW1'(h_eff))
                      && (out_col >= CW'(WIN_HALF))
                      && ((CW1'(out_col) + CW1'(WIN_HALF)) < CW1'(w_eff));
        res_last    = (out_row == h_ext - ROW_W'(1)) && (out_col == w_eff - CW'(1));
        wrap        = col_ext == w_eff - CW'(1);
        mem_wr      = act && !flushing;
    end

    // Position counters; any config write or the last result restarts the image
    always_comb
    begin
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        if (cfg_wr_en)
        begin
            in_row_next = '0;
            in_col_next = '0;
        end
        else if (act)
        begin
            if (has_res && res_last)
            begin
                in_row_next = '0;
                in_col_next = '0;
            end
            else if (wrap)
            begin
                in_row_next = in_row_reg + ROW_W'(1);
                in_col_next = '0;
            end
            else
            begin
                in_col_next = in_col_reg + AW'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= RESET_WIDTH;
            height_cfg_reg <= RESET_HEIGHT;
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            s2_res_reg     <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data[WIDTH_CFG_W-1:0];
                    REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data[HEIGHT_W-1:0];
                    default:          ;
                endcase
            end
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
            if (en)
            begin
                s1_valid_reg  <= act;
                s2_res_reg    <= s1_valid_reg && s1_res_reg;
                s3_valid_reg  <= s2_res_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Line buffer: read old column word before this item's byte lands
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            line_mem[in_col_reg][in_row_reg[SLOT_W-1:0]] <= pix_new;
        end
        if (act)
        begin
            line_rd_reg <= line_mem[in_col_reg];
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_res_reg    <= has_res;
            s1_filt_reg   <= res_filt;
            s1_last_reg   <= res_last;
            s1_pix_reg    <= pix_new;
            s1_slot_reg   <= in_row_reg[SLOT_W-1:0];
            s2_filt_reg   <= s1_filt_reg;
            s2_last_reg   <= s1_last_reg;
            s3_filt_reg   <= s2_filt_reg;
            s3_last_reg   <= s2_last_reg;
            s3_sum_reg    <= cell_acc[WIN];
            s3_center_reg <= cell_col[WIN_HALF].pix[WIN_HALF];
            s4_filt_reg   <= s3_filt_reg;
            s4_last_reg   <= s3_last_reg;
            s4_prod_reg   <= PROD_W'(s3_sum_reg) * PROD_W'(RECIP);
            s4_center_reg <= s3_center_reg;
            out_last_reg  <= s4_last_reg;
            out_pix_reg   <= s4_filt_reg ? s4_prod_reg[RECIP_SHIFT +: PIX_W] : s4_center_reg;
        end
    end

    // New column: rows r-4..r-1 from the buffers (rotated by slot), row r is the pixel
    always_comb
    begin
        logic [COLSUM_W-1:0] colsum;
        colsum = '0;
        for (int k = 0; k < LINES; k++)
        begin
            new_col.pix[k] = line_rd_reg[SLOT_W'(s1_slot_reg + SLOT_W'(k))];
            colsum         = colsum + COLSUM_W'(new_col.pix[k]);
        end
        new_col.pix[WIN-1] = s1_pix_reg;
        new_col.sum        = colsum + COLSUM_W'(s1_pix_reg);
    end

    assign win_shift   = en && s1_valid_reg;
    assign cell_acc[0] = '0;

    // Cell WIN-1 takes the newest column, cell 0 holds the oldest
    for (genvar j = 0; j < WIN; j++)
    begin : g_cell
        if (j == WIN - 1)
        begin : g_head
            bmf_win_cell u_cell (
                .clk      (clk),
                .shift_en (win_shift),
                .col_in   (new_col),
                .col_out  (cell_col[j]),
                .acc_in   (cell_acc[j]),
                .acc_out  (cell_acc[j+1])
            );
        end
        else
        begin : g_body
            bmf_win_cell u_cell (
                .clk      (clk),
                .shift_en (win_shift),
                .col_in   (cell_col[j+1]),
                .col_out  (cell_col[j]),
                .acc_in   (cell_acc[j]),
                .acc_out  (cell_acc[j+1])
            );
        end
    end

    // Output channel
    assign results.valid      = out_valid_reg;
    assign results.pixel_out  = out_pix_reg;
    assign results.last_pixel = out_last_reg;

    // Column position stays inside the image row
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_ext < w_eff)
        else $error("column counter beyond image width");

    // Row position never runs past the two flush rows
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        RW1'(in_row_reg) <= RW1'(h_eff) + RW1'(WIN_HALF))
        else $error("row counter beyond flush range");

    // The last result restarts the position counters
    a_restart_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (act && has_res && res_last) |=> (in_row_reg == '0 && in_col_reg == '0))
        else $error("counters not cleared after last pixel");

    // The final pixel of an image is a border pixel, never a filtered one
    a_last_is_border: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_res_reg && s1_filt_reg) |-> !s1_last_reg)
        else $error("last pixel flagged as filtered");

endmodule
